// File: rtl/ffea_pkg.sv
// Shared types, codes and constants of the first-fit extent allocator.
// No dependencies; every module of the allocator imports this package.
package ffea_pkg;

    localparam int ADDR_BITS       = 24;
    localparam int LEN_BITS        = ADDR_BITS + 1;
    localparam int DEF_MAX_EXTENTS = 64;
    localparam logic [LEN_BITS-1:0] POOL_MAX = LEN_BITS'(1) << ADDR_BITS;

    localparam logic REQ_ALLOC = 1'b0;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_FULL    = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_ZERO    = 3'd4
    } status_t;

    typedef struct packed {
        logic                 req_type;
        logic [LEN_BITS-1:0]  req_size;
        logic [ADDR_BITS-1:0] req_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] grant_offset;
        logic [LEN_BITS-1:0]  free_total;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_BITS-1:0]  len;
    } extent_t;

    // table read address select
    typedef enum logic [1:0] {
        RD_IDX    = 2'd0,
        RD_IDX_P1 = 2'd1,
        RD_IDX_M1 = 2'd2
    } rd_sel_t;

    // table write operation
    typedef enum logic [2:0] {
        WR_NONE       = 3'd0,
        WR_CUT        = 3'd1,
        WR_PREV_ADD   = 3'd2,
        WR_MERGE_BOTH = 3'd3,
        WR_NEXT_ADD   = 3'd4,
        WR_MOVE       = 3'd5,
        WR_NEW        = 3'd6
    } wr_op_t;

    typedef struct packed {
        logic    latch_req;
        logic    init_mem;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_load_cnt;
        logic    save_prev;
        logic    save_next;
        logic    save_pos;
        wr_op_t  wr_op;
        logic    set_st;
        status_t st;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    free_sub;
        logic    free_add;
        logic    save_grant;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic size_zero;
        logic end_over;
        logic cnt_zero;
        logic fit;
        logic exact;
        logic last;
        logic le_ofs;
        logic overlap;
        logic prev_join;
        logic next_join;
        logic full;
        logic dn_more;
        logic up_more;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/first_fit_extent_allocator.sv
// First-fit extent allocator: m_valid rises after the table walk over the entries visited,
// plus the merge or entry shift that a return or an exact fit needs.
// Takes one request at a time: a new word is accepted only after the last result is loaded,
// and that load waits until the previous result word is taken on m_ready.
// Reset: synchronous, active low; table holds [0, 2^24), written in an init state
// after reset before the first word is taken. A pool_size write reloads it.
module first_fit_extent_allocator
    import ffea_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  req_t                s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rsp_t                m_data,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ffea_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table and arithmetic
    ffea_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// File: rtl/ffea_ctrl.sv
// Sequencer of the extent allocator: walks, merges and table shifts.
// Depends on ffea_pkg; drives the datapath through cmd_t, reads stat_t.
module ffea_ctrl
    import ffea_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_INIT = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_DISP = 11'b000_0000_0100,
        S_RD   = 11'b000_0000_1000,
        S_CHK  = 11'b000_0001_0000,
        S_DEC  = 11'b000_0010_0000,
        S_MVR  = 11'b000_0100_0000,
        S_MVW  = 11'b000_1000_0000,
        S_UPR  = 11'b001_0000_0000,
        S_UPW  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_mem = 1'b1;
                state_next   = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.size_zero) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_ZERO;
                    state_next = S_FIN;
                end else if (stat.is_alloc) begin
                    if (stat.cnt_zero) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_NOFIT;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                    end
                end else if (stat.end_over) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_OVERLAP;
                    state_next = S_FIN;
                end else if (stat.cnt_zero) begin
                    state_next = S_DEC;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.is_alloc) begin
                    if (stat.fit) begin
                        cmd.save_grant = 1'b1;
                        cmd.free_sub   = 1'b1;
                        cmd.set_st     = 1'b1;
                        cmd.st         = ST_OK;
                        if (stat.exact) begin
                            state_next = S_MVR;
                        end else begin
                            cmd.wr_op  = WR_CUT;
                            state_next = S_FIN;
                        end
                    end else if (stat.last) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_NOFIT;
                        state_next = S_FIN;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end else if (stat.le_ofs) begin
                    cmd.save_prev = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = stat.last ? S_DEC : S_RD;
                end else begin
                    cmd.save_next = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC: begin
                cmd.set_st = 1'b1;
                if (stat.overlap) begin
                    cmd.st     = ST_OVERLAP;
                    state_next = S_FIN;
                end else if (stat.prev_join && stat.next_join) begin
                    cmd.st       = ST_OK;
                    cmd.wr_op    = WR_MERGE_BOTH;
                    cmd.free_add = 1'b1;
                    state_next   = S_MVR;
                end else if (stat.prev_join) begin
                    cmd.st       = ST_OK;
                    cmd.wr_op    = WR_PREV_ADD;
                    cmd.free_add = 1'b1;
                    state_next   = S_FIN;
                end else if (stat.next_join) begin
                    cmd.st       = ST_OK;
                    cmd.wr_op    = WR_NEXT_ADD;
                    cmd.free_add = 1'b1;
                    state_next   = S_FIN;
                end else if (stat.full) begin
                    cmd.st     = ST_FULL;
                    state_next = S_FIN;
                end else begin
                    cmd.st           = ST_OK;
                    cmd.free_add     = 1'b1;
                    cmd.save_pos     = 1'b1;
                    cmd.idx_load_cnt = 1'b1;
                    state_next       = S_UPR;
                end
            end
            // close the gap: move entries down one place
            S_MVR: begin
                if (stat.dn_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_MVW;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_MVW: begin
                cmd.wr_op   = WR_MOVE;
                cmd.idx_inc = 1'b1;
                state_next  = S_MVR;
            end
            // open a gap: move entries up one place, then fill it
            S_UPR: begin
                if (stat.up_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_UPW;
                end else begin
                    cmd.wr_op   = WR_NEW;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_UPW: begin
                cmd.wr_op   = WR_MOVE;
                cmd.idx_dec = 1'b1;
                state_next  = S_UPR;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// File: rtl/ffea_dp.sv
// Datapath of the extent allocator: extent table memory, pointers,
// free total, pool size and result register. Depends on ffea_pkg.
module ffea_dp
    import ffea_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  req_t                s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rsp_t                m_data,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data,
    input  cmd_t                cmd,
    output stat_t               stat
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

    extent_t mem [MAX_EXTENTS];
    extent_t rd_q;

    req_t                 req_reg;
    logic [CW-1:0]        idx_reg, pos_reg, count_reg;
    logic [ADDR_BITS-1:0] prev_s_reg, nxt_s_reg, grant_reg;
    logic [LEN_BITS-1:0]  prev_l_reg, nxt_l_reg;
    logic                 prev_vld_reg, nxt_vld_reg;
    logic [LEN_BITS-1:0]  free_reg, pool_reg;
    status_t              st_reg;
    rsp_t                 out_reg;
    logic                 out_vld_reg;

    logic [LEN_BITS-1:0]  pool_cfg;
    logic [LEN_BITS:0]    req_end, prev_end;
    logic [CW-1:0]        idx_p1, idx_m1, rd_idx, wr_idx;
    logic                 wr_en;
    extent_t              wr_data;

    // clamp written pool size to the addressable range
    assign pool_cfg = (cfg_wr_data > POOL_MAX) ? POOL_MAX : cfg_wr_data;

    assign req_end  = {2'b00, req_reg.req_offset} + {1'b0, req_reg.req_size};
    assign prev_end = {2'b00, prev_s_reg} + {1'b0, prev_l_reg};
    assign idx_p1   = idx_reg + CW'(1);
    assign idx_m1   = idx_reg - CW'(1);

    // status toward the sequencer
    always_comb begin
        stat.is_alloc  = (req_reg.req_type == REQ_ALLOC);
        stat.size_zero = (req_reg.req_size == '0);
        stat.end_over  = (req_end > {1'b0, pool_reg});
        stat.cnt_zero  = (count_reg == '0);
        stat.fit       = (rd_q.len >= req_reg.req_size);
        stat.exact     = (rd_q.len == req_reg.req_size);
        stat.last      = (idx_p1 == count_reg);
        stat.le_ofs    = (rd_q.start <= req_reg.req_offset);
        stat.overlap   = (prev_vld_reg && (prev_end > {2'b00, req_reg.req_offset}))
                      || (nxt_vld_reg && (req_end > {2'b00, nxt_s_reg}));
        stat.prev_join = prev_vld_reg && (prev_end == {2'b00, req_reg.req_offset});
        stat.next_join = nxt_vld_reg && (req_end == {2'b00, nxt_s_reg});
        stat.full      = (count_reg >= CNT_MAX);
        stat.dn_more   = (idx_p1 < count_reg);
        stat.up_more   = (idx_reg > pos_reg);
        stat.out_free  = !out_vld_reg || m_ready;
    end

    // read address select
    always_comb begin
        unique case (cmd.rd_sel)
            RD_IDX:    rd_idx = idx_reg;
            RD_IDX_P1: rd_idx = idx_p1;
            RD_IDX_M1: rd_idx = idx_m1;
            default:   rd_idx = idx_reg;
        endcase
    end

    // write port: configuration reload wins over table edits
    always_comb begin
        wr_en   = 1'b1;
        wr_idx  = idx_reg;
        wr_data = rd_q;
        if (cfg_wr_en) begin
            wr_idx  = '0;
            wr_data = '{start: '0, len: pool_cfg};
        end else if (cmd.init_mem) begin
            wr_idx  = '0;
            wr_data = '{start: '0, len: pool_reg};
        end else begin
            unique case (cmd.wr_op)
                WR_NONE: begin
                    wr_en = 1'b0;
                end
                WR_CUT: begin
                    wr_data.start = rd_q.start + req_reg.req_size[ADDR_BITS-1:0];
                    wr_data.len   = rd_q.len - req_reg.req_size;
                end
                WR_PREV_ADD: begin
                    wr_idx  = idx_m1;
                    wr_data = '{start: prev_s_reg, len: prev_l_reg + req_reg.req_size};
                end
                WR_MERGE_BOTH: begin
                    wr_idx  = idx_m1;
                    wr_data = '{start: prev_s_reg,
                                len: prev_l_reg + req_reg.req_size + nxt_l_reg};
                end
                WR_NEXT_ADD: begin
                    wr_data = '{start: req_reg.req_offset,
                                len: nxt_l_reg + req_reg.req_size};
                end
                WR_MOVE: begin
                    wr_data = rd_q;
                end
                WR_NEW: begin
                    wr_idx  = pos_reg;
                    wr_data = '{start: req_reg.req_offset, len: req_reg.req_size};
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // extent table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_q <= mem[rd_idx[AW-1:0]];
        end
    end

    // request, walk pointers and saved neighbors
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg <= s_data;
        end
        if (cmd.latch_req) begin
            idx_reg <= '0;
        end else if (cmd.idx_load_cnt) begin
            idx_reg <= count_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_p1;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_m1;
        end
        if (cmd.save_pos) begin
            pos_reg <= idx_reg;
        end
        if (cmd.save_prev) begin
            prev_s_reg <= rd_q.start;
            prev_l_reg <= rd_q.len;
        end
        if (cmd.save_next) begin
            nxt_s_reg <= rd_q.start;
            nxt_l_reg <= rd_q.len;
        end
        if (cmd.set_st) begin
            st_reg <= cmd.st;
        end
        if (cmd.latch_req) begin
            grant_reg <= '0;
        end else if (cmd.save_grant) begin
            grant_reg <= rd_q.start;
        end
    end

    // control state: counts, flags, pool and free total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= CW'(1);
            free_reg     <= POOL_MAX;
            pool_reg     <= POOL_MAX;
            prev_vld_reg <= 1'b0;
            nxt_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pool_reg  <= pool_cfg;
                free_reg  <= pool_cfg;
                count_reg <= CW'(pool_cfg != '0);
            end else begin
                if (cmd.cnt_inc) begin
                    count_reg <= count_reg + CW'(1);
                end else if (cmd.cnt_dec) begin
                    count_reg <= count_reg - CW'(1);
                end
                if (cmd.free_sub) begin
                    free_reg <= free_reg - req_reg.req_size;
                end else if (cmd.free_add) begin
                    free_reg <= free_reg + req_reg.req_size;
                end
            end
            if (cmd.latch_req) begin
                prev_vld_reg <= 1'b0;
                nxt_vld_reg  <= 1'b0;
            end else begin
                if (cmd.save_prev) begin
                    prev_vld_reg <= 1'b1;
                end
                if (cmd.save_next) begin
                    nxt_vld_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= st_reg;
            out_reg.grant_offset <= (st_reg == ST_OK) ? grant_reg : '0;
            out_reg.free_total   <= free_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("extent count above table depth");

    a_free_le_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= pool_reg)
        else $error("free total exceeds pool size");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result word lost after load");

    a_cnt_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count raised and lowered together");

endmodule
